// ----- rtl/tmb_pkg.sv -----
`default_nettype none
package tmb_pkg;

  typedef enum logic [2:0] {
    OP_REGISTER  = 3'd0,
    OP_TICK      = 3'd1,
    OP_CLEAR_ID  = 3'd2,
    OP_CLEAR_REP = 3'd3,
    OP_CLEAR_ALL = 3'd4,
    OP_SPARE5    = 3'd5,
    OP_SPARE6    = 3'd6,
    OP_SPARE7    = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    CMD_REG,
    CMD_TICK,
    CMD_CLR_ID,
    CMD_CLR_REP,
    CMD_CLR_ALL,
    CMD_NOP
  } cmd_kind_t;

  typedef enum logic [1:0] {
    EV_WAKE = 2'd0,
    EV_DROP = 2'd1,
    EV_DONE = 2'd2
  } event_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REG,
    ST_READ,
    ST_EVAL,
    ST_DROP,
    ST_DONE
  } eng_state_t;

  localparam logic PERIODIC_FLAG = 1'b1;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] now_ticks;
    logic [31:0] wait_ticks;
    logic        repeat_mode;
    logic [15:0] timer_id;
  } cmd_t;

endpackage
`default_nettype wire

// ----- rtl/tmb_ram.sv -----
`default_nettype none
module tmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/tmb_front.sv -----
`default_nettype none
module tmb_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [2:0]    in_op,
  input  wire logic [31:0]   in_now,
  input  wire logic [31:0]   in_wait,
  input  wire logic          in_rep,
  input  wire logic [15:0]   in_tid,
  output logic               cmd_valid,
  input  wire logic          cmd_pop,
  output tmb_pkg::cmd_t      cmd
);

  // Two-entry command queue between the decoder and the slot engine.
  tmb_pkg::cmd_t q [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;
  tmb_pkg::cmd_t dec;
  logic          push;
  logic          pop;

  always_comb begin
    case (tmb_pkg::op_t'(in_op))
      tmb_pkg::OP_REGISTER:  dec.kind = tmb_pkg::CMD_REG;
      tmb_pkg::OP_TICK:      dec.kind = tmb_pkg::CMD_TICK;
      tmb_pkg::OP_CLEAR_ID:  dec.kind = tmb_pkg::CMD_CLR_ID;
      tmb_pkg::OP_CLEAR_REP: dec.kind = tmb_pkg::CMD_CLR_REP;
      tmb_pkg::OP_CLEAR_ALL: dec.kind = tmb_pkg::CMD_CLR_ALL;
      default:               dec.kind = tmb_pkg::CMD_NOP;
    endcase
    dec.now_ticks   = in_now;
    dec.wait_ticks  = in_wait;
    dec.repeat_mode = in_rep;
    dec.timer_id    = in_tid;
  end

  assign in_ready  = (fill != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (fill != 2'd0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= dec;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/tmb_engine.sv -----
`default_nettype none
module tmb_engine #(
  parameter int SLOTS   = 16,
  parameter int ID_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_pop,
  input  wire tmb_pkg::cmd_t cmd,
  output logic               ev_valid,
  input  wire logic          ev_ready,
  output logic [1:0]         ev_kind,
  output logic [15:0]        ev_id,
  output logic [4:0]         ev_count,
  output logic               ev_status,
  output logic               ev_last
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int NW = $clog2(SLOTS + 1);
  localparam int XW = (ID_BITS > 16) ? ID_BITS : 16;
  localparam int RW = ID_BITS + 65;

  // Slot order: entries below n are live slots, newest first; the rest are free.
  logic [SW-1:0] ord [SLOTS];
  logic [SW-1:0] ord_next [SLOTS];
  logic [NW-1:0] n;
  logic [NW-1:0] n_next;
  logic [NW-1:0] k;
  logic [NW-1:0] k_next;
  logic [NW-1:0] nm1;

  tmb_pkg::eng_state_t state;
  tmb_pkg::eng_state_t state_next;
  tmb_pkg::cmd_t       cur;
  logic [ID_BITS-1:0]  next_id;
  logic [ID_BITS-1:0]  next_id_next;
  logic [4:0]          cnt;
  logic [4:0]          cnt_next;
  logic [15:0]         done_id;
  logic [15:0]         done_id_next;
  logic                done_st;
  logic                done_st_next;

  logic               ram_we;
  logic [SW-1:0]      ram_waddr;
  logic [RW-1:0]      ram_wdata;
  logic               ram_re;
  logic [SW-1:0]      ram_raddr;
  logic [RW-1:0]      ram_rdata;

  logic [ID_BITS-1:0] rd_id;
  logic [31:0]        rd_wait;
  logic [31:0]        rd_start;
  logic               rd_per;
  logic [XW-1:0]      rd_id_x;
  logic [31:0]        elapsed;
  logic               due;
  logic               hit;
  logic               emit_ok;
  logic               emit;
  tmb_pkg::event_kind_t emit_kind;
  logic [15:0]        emit_id;
  logic [4:0]         emit_cnt;
  logic               emit_st;
  logic               emit_last;

  tmb_ram #(.WIDTH(RW), .DEPTH(SLOTS)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_id    = ram_rdata[ID_BITS-1:0];
  assign rd_wait  = ram_rdata[ID_BITS+31:ID_BITS];
  assign rd_start = ram_rdata[ID_BITS+63:ID_BITS+32];
  assign rd_per   = ram_rdata[ID_BITS+64];
  assign rd_id_x  = XW'(rd_id);
  assign elapsed  = cur.now_ticks - rd_start;
  assign due      = (elapsed >= rd_wait);
  assign nm1      = n - NW'(1);
  assign emit_ok  = !ev_valid || ev_ready;

  always_comb begin
    case (cur.kind)
      tmb_pkg::CMD_CLR_ALL: hit = 1'b1;
      tmb_pkg::CMD_CLR_ID:  hit = (rd_id_x == XW'(cur.timer_id));
      tmb_pkg::CMD_CLR_REP: hit = (rd_per == cur.repeat_mode);
      default:              hit = 1'b0;
    endcase
  end

  always_comb begin
    state_next   = state;
    ord_next     = ord;
    n_next       = n;
    k_next       = k;
    cnt_next     = cnt;
    next_id_next = next_id;
    done_id_next = done_id;
    done_st_next = done_st;
    cmd_pop      = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = ord[k[SW-1:0]];
    ram_wdata    = {rd_per, cur.now_ticks, rd_wait, rd_id};
    ram_re       = 1'b0;
    ram_raddr    = ord[k[SW-1:0]];
    emit         = 1'b0;
    emit_kind    = tmb_pkg::EV_DONE;
    emit_id      = rd_id_x[15:0];
    emit_cnt     = 5'd0;
    emit_st      = 1'b0;
    emit_last    = 1'b0;

    case (state)
      tmb_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop      = 1'b1;
          k_next       = '0;
          cnt_next     = 5'd0;
          done_id_next = 16'd0;
          done_st_next = 1'b0;
          case (cmd.kind)
            tmb_pkg::CMD_REG: state_next = tmb_pkg::ST_REG;
            tmb_pkg::CMD_NOP: state_next = tmb_pkg::ST_DONE;
            default:          state_next = tmb_pkg::ST_READ;
          endcase
        end
      end

      tmb_pkg::ST_REG: begin
        if (n == NW'(SLOTS)) begin
          done_st_next = 1'b1;
        end else begin
          ram_we       = 1'b1;
          ram_waddr    = ord[n[SW-1:0]];
          ram_wdata    = {cur.repeat_mode, cur.now_ticks, cur.wait_ticks, next_id};
          for (int i = 0; i < SLOTS; i++) begin
            if (i == 0) begin
              ord_next[0] = ord[n[SW-1:0]];
            end else if (i <= int'(n)) begin
              ord_next[i] = ord[i-1];
            end
          end
          n_next       = n + NW'(1);
          done_id_next = 16'(XW'(next_id));
          next_id_next = next_id + ID_BITS'(1);
        end
        state_next = tmb_pkg::ST_DONE;
      end

      tmb_pkg::ST_READ: begin
        if (k == n) begin
          state_next = tmb_pkg::ST_DONE;
        end else begin
          ram_re     = 1'b1;
          state_next = tmb_pkg::ST_EVAL;
        end
      end

      tmb_pkg::ST_EVAL: begin
        if (cur.kind == tmb_pkg::CMD_TICK) begin
          if (!due) begin
            k_next     = k + NW'(1);
            state_next = tmb_pkg::ST_READ;
          end else if (emit_ok) begin
            emit      = 1'b1;
            emit_kind = tmb_pkg::EV_WAKE;
            if (rd_per == tmb_pkg::PERIODIC_FLAG) begin
              ram_we     = 1'b1;
              k_next     = k + NW'(1);
              state_next = tmb_pkg::ST_READ;
            end else begin
              state_next = tmb_pkg::ST_DROP;
            end
          end
        end else if (!hit) begin
          k_next     = k + NW'(1);
          state_next = tmb_pkg::ST_READ;
        end else begin
          state_next = tmb_pkg::ST_DROP;
        end
      end

      tmb_pkg::ST_DROP: begin
        if (emit_ok) begin
          emit      = 1'b1;
          emit_kind = tmb_pkg::EV_DROP;
          for (int i = 0; i < SLOTS - 1; i++) begin
            if (i >= int'(k) && (i + 1) < int'(n)) begin
              ord_next[i] = ord[i+1];
            end
          end
          ord_next[nm1[SW-1:0]] = ord[k[SW-1:0]];
          n_next = nm1;
          if (cur.kind != tmb_pkg::CMD_TICK) begin
            cnt_next = cnt + 5'd1;
          end
          state_next = tmb_pkg::ST_READ;
        end
      end

      tmb_pkg::ST_DONE: begin
        if (emit_ok) begin
          emit       = 1'b1;
          emit_kind  = tmb_pkg::EV_DONE;
          emit_id    = done_id;
          emit_cnt   = cnt;
          emit_st    = done_st;
          emit_last  = 1'b1;
          state_next = tmb_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = tmb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd;
    end
    k       <= k_next;
    cnt     <= cnt_next;
    done_id <= done_id_next;
    done_st <= done_st_next;
    if (emit) begin
      ev_kind   <= emit_kind;
      ev_id     <= emit_id;
      ev_count  <= emit_cnt;
      ev_status <= emit_st;
      ev_last   <= emit_last;
    end
    if (rst) begin
      state    <= tmb_pkg::ST_IDLE;
      n        <= '0;
      next_id  <= '0;
      ev_valid <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        ord[i] <= SW'(i);
      end
    end else begin
      state   <= state_next;
      n       <= n_next;
      next_id <= next_id_next;
      ord     <= ord_next;
      if (emit) begin
        ev_valid <= 1'b1;
      end else if (ev_ready) begin
        ev_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/timeout_timer_bank.sv -----
`default_nettype none
// Bank of SLOTS timeout timers driven by a command stream.
// Input stream (s_*): one transfer is one operation. s_tuser carries the op code
// (register, tick, clear by id, clear by repeat flag, clear all); s_tdata carries
// the tick count, wait length, repeat flag and the timer id used by clear by id.
// Output stream (m_*): each operation produces a run of wake and drop events,
// newest registered timer first, closed by one done record marked with m_tlast.
// The done record carries the new id for register, the number of dropped timers
// for the clear ops, and a status bit that flags a register into a full bank.
// A decoder with a two-entry queue takes operations while the slot engine is busy.
// The engine visits the live slots one at a time, a read state and then an
// evaluate state per slot, through a slot memory with one read and one write
// port; each drop event adds a drop state. A register op writes a free slot, if
// one is left. The engine takes the next op only after the last op's done record.
// When the receiver stalls, the engine holds its next event and stops; the
// queue fills and s_tready falls. Reset empties the bank, frees all slots,
// sets the next id to zero and drops any queued operations; no clearing pass.
module timeout_timer_bank #(
  parameter int SLOTS   = 16,
  parameter int ID_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // s_tdata: now_ticks[31:0], wait_ticks[63:32], repeat_mode[64], timer_id[80:65]
  input  wire logic [87:0] s_tdata,
  // s_tuser: op[2:0]
  input  wire logic [2:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // m_tdata: event_id[15:0], count[20:16], status[21]
  output logic [23:0]      m_tdata,
  // m_tuser: event_kind[1:0]
  output logic [1:0]       m_tuser,
  output logic             m_tlast
);

  logic          cmd_valid;
  logic          cmd_pop;
  tmb_pkg::cmd_t cmd;
  logic [15:0]   ev_id;
  logic [4:0]    ev_count;
  logic          ev_status;

  // Front end: op decode and command queue.
  tmb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (s_tuser),
    .in_now    (s_tdata[31:0]),
    .in_wait   (s_tdata[63:32]),
    .in_rep    (s_tdata[64]),
    .in_tid    (s_tdata[80:65]),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  // Back end: slot store, age-ordered scan and the output register.
  tmb_engine #(.SLOTS(SLOTS), .ID_BITS(ID_BITS)) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .ev_valid  (m_tvalid),
    .ev_ready  (m_tready),
    .ev_kind   (m_tuser),
    .ev_id     (ev_id),
    .ev_count  (ev_count),
    .ev_status (ev_status),
    .ev_last   (m_tlast)
  );

  assign m_tdata = {2'b00, ev_status, ev_count, ev_id};

endmodule
`default_nettype wire
